/* src/plm_pkg.sv */
package plm_pkg;

  localparam int NumMonitorsDefault = 8;
  localparam int ParamCountDefault  = 256;
  localparam int MaxEvents          = 8;

  typedef enum logic [2:0] {
    FUNC_DEFINE  = 3'd0,
    FUNC_ENABLE  = 3'd1,
    FUNC_DISABLE = 3'd2,
    FUNC_DELETE  = 3'd3,
    FUNC_TICK    = 3'd4,
    FUNC_WRITE   = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ANS_ACCEPTED  = 3'd0,
    ANS_BAD_SLOT  = 3'd1,
    ANS_BUSY_SLOT = 3'd2,
    ANS_BAD_PARAM = 3'd3,
    ANS_UNDEFINED = 3'd4
  } answer_t;

  typedef enum logic [2:0] {
    ST_UNSELECTED = 3'd0,
    ST_UNCHECKED  = 3'd1,
    ST_WITHIN     = 3'd2,
    ST_BELOW      = 3'd3,
    ST_ABOVE      = 3'd4
  } status_t;

  localparam logic RESULT_ANSWER = 1'b0;
  localparam logic RESULT_EVENT  = 1'b1;

  // One slot record as held in the slot memory.
  typedef struct packed {
    logic [7:0]  param;
    logic [7:0]  interval;
    logic [7:0]  counter;
    logic [2:0]  status;
    logic        enabled;
    logic [15:0] low_limit;
    logic [15:0] low_report;
    logic [15:0] high_limit;
    logic [15:0] high_report;
  } slot_t;

  localparam int SlotWidth = $bits(slot_t);

  localparam slot_t SlotReset = '{
    param: 8'd0, interval: 8'd1, counter: 8'd0, status: ST_UNSELECTED, enabled: 1'b0,
    low_limit: 16'd0, low_report: 16'd0, high_limit: 16'd0, high_report: 16'd0
  };

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] monitor_index;
    logic [15:0] param_id;
    logic [7:0]  check_interval;
    logic [15:0] low_limit;
    logic [15:0] low_report_id;
    logic [15:0] high_limit;
    logic [15:0] high_report_id;
    logic [15:0] param_value;
  } cmd_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  answer_code;
    logic [15:0] rejected_id;
    logic [15:0] event_report_id;
    logic [7:0]  event_param;
    logic [15:0] event_value;
    logic [15:0] event_limit;
    logic        last_result;
  } res_t;

endpackage

/* src/plm_cmd_if.sv */
interface plm_cmd_if;
  logic               valid;
  logic               ready;
  plm_pkg::cmd_t      payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/plm_res_if.sv */
interface plm_res_if;
  logic               valid;
  logic               ready;
  plm_pkg::res_t      payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/plm_ram.sv */
module plm_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/parameter_limit_monitor.sv */
// Parameter limit monitor. Slot records and the parameter store sit in two
// single-port-read RAMs with registered read data; after reset a clearing
// pass writes both, during which no transaction is accepted. A command is
// accepted and its slot read in S_IDLE, read again in S_CREAD, then evaluated
// and written back in S_CEXEC while the answer goes to the output register,
// which S_CEXEC waits for while it is full; a write stores its parameter in
// S_CREAD and returns to idle. A tick walks the slots one at a time, each in
// three steps (slot read, parameter read, evaluate and write back), and waits
// while the output still has to drain an answer or event.
// Parameter ids are narrowed to the store address; parameter numbers at or
// above PARAM_COUNT are rejected at define and ignored at write.
module parameter_limit_monitor #(
  parameter int NUM_MONITORS = plm_pkg::NumMonitorsDefault,
  parameter int PARAM_COUNT  = plm_pkg::ParamCountDefault
) (
  input  logic      clk,
  input  logic      rst,
  plm_cmd_if.sink   cmd,
  plm_res_if.source res
);
  localparam int SlotAw  = (NUM_MONITORS > 1) ? $clog2(NUM_MONITORS) : 1;
  localparam int SlotDp  = 1 << SlotAw;
  localparam int ParAw   = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int ParDp   = 1 << ParAw;
  localparam int ClrMax  = (SlotDp > ParDp) ? SlotDp : ParDp;
  localparam int ClrW    = $clog2(ClrMax) + 1;
  localparam int EvW     = $clog2(plm_pkg::MaxEvents) + 1;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_CREAD  = 8'b00000100,
    S_CEXEC  = 8'b00001000,
    S_TREAD  = 8'b00010000,
    S_TPAR   = 8'b00100000,
    S_TEXEC  = 8'b01000000,
    S_TDONE  = 8'b10000000
  } state_t;

  state_t state, state_next;
  plm_pkg::cmd_t cur;
  logic [ClrW-1:0] clr_cnt;
  logic [SlotAw:0] slot_idx;
  logic [EvW-1:0]  ev_cnt;

  // Pending last event of a tick: held until we know whether another follows.
  logic            pend_valid;
  plm_pkg::res_t   pend;

  logic            out_valid;
  plm_pkg::res_t   out_data;

  plm_pkg::slot_t  slot_rd, slot_wd;
  logic            slot_we;
  logic [SlotAw-1:0] slot_waddr, slot_raddr;
  logic [15:0]     par_rd, par_wd;
  logic            par_we;
  logic [ParAw-1:0] par_waddr, par_raddr;

  plm_ram #(.Width(plm_pkg::SlotWidth), .Depth(SlotDp)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wd),
    .raddr(slot_raddr), .rdata(slot_rd)
  );

  plm_ram #(.Width(16), .Depth(ParDp)) u_par_ram (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wd),
    .raddr(par_raddr), .rdata(par_rd)
  );

  logic out_free;
  assign out_free  = !out_valid || res.ready;
  assign cmd.ready = (state == S_IDLE) && !pend_valid;
  assign res.valid = out_valid;
  assign res.payload = out_data;

  logic accept;
  assign accept = cmd.valid && cmd.ready;

  logic mon_ok, pid_ok;
  assign mon_ok = cur.monitor_index < 16'(NUM_MONITORS);
  assign pid_ok = cur.param_id < 16'(PARAM_COUNT);

  // Tick evaluation of the slot just read.
  plm_pkg::slot_t tk_slot;
  logic           tk_event;
  plm_pkg::res_t  tk_res;
  always_comb begin
    tk_slot  = slot_rd;
    tk_event = 1'b0;
    tk_res   = '0;
    tk_res.result_kind = plm_pkg::RESULT_EVENT;
    tk_res.event_param = slot_rd.param;
    tk_res.event_value = par_rd;
    if (slot_rd.enabled) begin
      if (slot_rd.counter < slot_rd.interval) begin
        tk_slot.counter = slot_rd.counter + 8'd1;
      end else begin
        tk_slot.counter = 8'd0;
        if (slot_rd.status != plm_pkg::ST_UNSELECTED) begin
          if (slot_rd.status != plm_pkg::ST_ABOVE && slot_rd.status != plm_pkg::ST_BELOW) begin
            if (slot_rd.high_limit < par_rd) begin
              tk_event = 1'b1;
              tk_res.event_report_id = slot_rd.high_report;
              tk_res.event_limit     = slot_rd.high_limit;
              tk_slot.status         = plm_pkg::ST_ABOVE;
            end else if (slot_rd.low_limit > par_rd) begin
              tk_event = 1'b1;
              tk_res.event_report_id = slot_rd.low_report;
              tk_res.event_limit     = slot_rd.low_limit;
              tk_slot.status         = plm_pkg::ST_BELOW;
            end else if (slot_rd.status == plm_pkg::ST_UNCHECKED) begin
              tk_slot.status = plm_pkg::ST_WITHIN;
            end
          end else if (slot_rd.high_limit > par_rd && slot_rd.low_limit < par_rd) begin
            tk_slot.status = plm_pkg::ST_WITHIN;
          end
        end
      end
    end
  end

  // Command evaluation on the slot just read.
  plm_pkg::slot_t cm_slot;
  logic           cm_we, cm_ans;
  plm_pkg::res_t  cm_res;
  always_comb begin
    cm_slot = slot_rd;
    cm_we   = 1'b0;
    cm_ans  = 1'b1;
    cm_res  = '0;
    cm_res.result_kind = plm_pkg::RESULT_ANSWER;
    cm_res.last_result = 1'b1;
    cm_res.answer_code = plm_pkg::ANS_ACCEPTED;
    case (plm_pkg::func_t'(cur.func))
      plm_pkg::FUNC_DEFINE: begin
        if (!mon_ok) begin
          cm_res.answer_code = plm_pkg::ANS_BAD_SLOT;
          cm_res.rejected_id = cur.monitor_index;
        end else if (slot_rd.status != plm_pkg::ST_UNSELECTED) begin
          cm_res.answer_code = plm_pkg::ANS_BUSY_SLOT;
          cm_res.rejected_id = cur.monitor_index;
        end else if (!pid_ok) begin
          cm_res.answer_code = plm_pkg::ANS_BAD_PARAM;
          cm_res.rejected_id = cur.param_id;
        end else begin
          cm_we = 1'b1;
          cm_slot.param       = cur.param_id[7:0];
          cm_slot.interval    = cur.check_interval;
          cm_slot.counter     = 8'd0;
          cm_slot.status      = plm_pkg::ST_UNCHECKED;
          cm_slot.low_limit   = cur.low_limit;
          cm_slot.low_report  = cur.low_report_id;
          cm_slot.high_limit  = cur.high_limit;
          cm_slot.high_report = cur.high_report_id;
        end
      end
      plm_pkg::FUNC_ENABLE, plm_pkg::FUNC_DISABLE, plm_pkg::FUNC_DELETE: begin
        if (!mon_ok) begin
          cm_ans = 1'b0;
        end else if (slot_rd.status == plm_pkg::ST_UNSELECTED) begin
          cm_res.answer_code = plm_pkg::ANS_UNDEFINED;
          cm_res.rejected_id = cur.monitor_index;
        end else begin
          cm_we = 1'b1;
          if (cur.func == plm_pkg::FUNC_ENABLE) begin
            cm_slot.enabled = 1'b1;
            cm_slot.counter = 8'd0;
          end else if (cur.func == plm_pkg::FUNC_DISABLE) begin
            cm_slot.enabled = 1'b0;
          end else begin
            cm_slot.status = plm_pkg::ST_UNSELECTED;
          end
        end
      end
      default: cm_ans = 1'b0;
    endcase
  end

  logic [SlotAw-1:0] cur_slot;
  assign cur_slot = cur.monitor_index[SlotAw-1:0];
  logic [SlotAw-1:0] walk;
  assign walk = slot_idx[SlotAw-1:0];
  logic tk_emit;
  assign tk_emit = tk_event && (ev_cnt < EvW'(plm_pkg::MaxEvents));
  logic last_slot;
  assign last_slot = slot_idx == (SlotAw+1)'(NUM_MONITORS - 1);

  // Memory ports.
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = walk;
    slot_wd    = tk_slot;
    slot_raddr = walk;
    par_we     = 1'b0;
    par_waddr  = cur.param_id[ParAw-1:0];
    par_wd     = cur.param_value;
    par_raddr  = slot_rd.param[ParAw-1:0];
    case (state)
      S_CLEAR: begin
        slot_we    = clr_cnt < ClrW'(SlotDp);
        slot_waddr = clr_cnt[SlotAw-1:0];
        slot_wd    = plm_pkg::SlotReset;
        par_we     = clr_cnt < ClrW'(ParDp);
        par_waddr  = clr_cnt[ParAw-1:0];
        par_wd     = 16'd0;
      end
      S_IDLE: begin
        slot_raddr = cmd.payload.monitor_index[SlotAw-1:0];
        par_we     = 1'b0;
      end
      S_CREAD: begin
        slot_raddr = cur_slot;
        par_we     = (cur.func == plm_pkg::FUNC_WRITE) && pid_ok;
      end
      S_CEXEC: begin
        // Keep reading the addressed slot so a stalled output sees the same record.
        slot_raddr = cur_slot;
        slot_we    = cm_we && mon_ok && out_free;
        slot_waddr = cur_slot;
        slot_wd    = cm_slot;
      end
      S_TEXEC: begin
        slot_we = !(tk_emit && pend_valid && !out_free);
      end
      default: ;
    endcase
  end

  logic tex_go;
  assign tex_go = !(tk_emit && pend_valid && !out_free);

  // What the output register takes this cycle, if anything.
  logic          out_load;
  plm_pkg::res_t out_load_data;
  always_comb begin
    out_load      = 1'b0;
    out_load_data = pend;
    case (state)
      S_CEXEC: begin
        out_load      = out_free && cm_ans && (mon_ok || cur.func == plm_pkg::FUNC_DEFINE);
        out_load_data = cm_res;
      end
      S_TEXEC: out_load = tex_go && tk_emit && pend_valid;
      S_TDONE: begin
        out_load                  = pend_valid && out_free;
        out_load_data.last_result = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_cnt == ClrW'(ClrMax - 1)) state_next = S_IDLE;
      S_IDLE:   if (accept) state_next = S_CREAD;
      S_CREAD: begin
        if (cur.func == plm_pkg::FUNC_TICK) state_next = S_TREAD;
        else if (cur.func == plm_pkg::FUNC_DEFINE || cur.func == plm_pkg::FUNC_ENABLE ||
                 cur.func == plm_pkg::FUNC_DISABLE || cur.func == plm_pkg::FUNC_DELETE)
          state_next = S_CEXEC;
        else state_next = S_IDLE;
      end
      S_CEXEC:  if (out_free) state_next = S_IDLE;
      S_TREAD:  state_next = S_TPAR;
      S_TPAR:   state_next = S_TEXEC;
      S_TEXEC:  if (tex_go) state_next = last_slot ? S_TDONE : S_TREAD;
      S_TDONE:  if (!pend_valid || out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      slot_idx   <= '0;
      ev_cnt     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= out_load_data;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr_cnt <= clr_cnt + ClrW'(1);
        S_CREAD: begin
          slot_idx <= '0;
          ev_cnt   <= '0;
        end
        S_TEXEC: begin
          if (tex_go) begin
            slot_idx <= slot_idx + (SlotAw+1)'(1);
            if (tk_emit) begin
              ev_cnt     <= ev_cnt + EvW'(1);
              pend_valid <= 1'b1;
              pend       <= tk_res;
            end
          end
        end
        S_TDONE: begin
          if (pend_valid && out_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
      if (accept) cur <= cmd.payload;
    end
  end

  // A pending event only exists while a tick is being walked or finished.
  ap_pend_tick: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == S_TREAD || state == S_TPAR || state == S_TEXEC ||
                    state == S_TDONE))
    else $error("pending event outside a tick");

  ap_ev_cap: assert property (@(posedge clk) disable iff (rst)
    ev_cnt <= EvW'(plm_pkg::MaxEvents))
    else $error("event count above limit");

  ap_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !cmd.ready)
    else $error("accepted during clearing pass");

  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> out_valid)
    else $error("result dropped");

endmodule
